[design/fan_duty_hysteresis_controller_macros.svh]
// ----------------------------------------------------------------------------
// Fan duty hysteresis controller: assertion macros
// Concurrent checks on the rising clock edge, muted during reset.
// ----------------------------------------------------------------------------
`ifndef FAN_DUTY_HYSTERESIS_CONTROLLER_MACROS_SVH
`define FAN_DUTY_HYSTERESIS_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define FDHC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FDHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fdhc_pkg.sv]
// ----------------------------------------------------------------------------
// fdhc_pkg
// Shared types, register indexes and constants of the fan duty controller.
// ----------------------------------------------------------------------------
package fdhc_pkg;

    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned TEMP_W     = 8;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned PARAM_W    = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned ENABLE_W   = 2;
    localparam int unsigned OUTQ_DEPTH = 4;

    localparam logic [DUTY_W-1:0] FULL_SPEED_RST = 8'd101;
    localparam logic [DUTY_W-1:0] STARTUP_RST    = 8'd50;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOC_PARAMS   = 3'd0,
        CFG_HDD_PARAMS   = 3'd1,
        CFG_AUX_PARAMS   = 3'd2,
        CFG_SENSOR_EN    = 3'd3,
        CFG_FULL_SPEED   = 3'd4,
        CFG_STARTUP_DUTY = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_FULL = 2'd1,
        MODE_VAR  = 2'd2
    } t_mode;

    // Threshold set, setpoint in the low byte
    typedef struct packed {
        logic [DUTY_W-1:0] duty_inc;
        logic [DUTY_W-1:0] max_duty;
        logic [DUTY_W-1:0] min_duty;
        logic [TEMP_W-1:0] temp_band;
        logic [TEMP_W-1:0] max_temp;
        logic [TEMP_W-1:0] setpoint;
    } t_params;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        t_mode             mode;
        logic              last;
    } t_result;

    function automatic t_mode mode_of(logic [DUTY_W-1:0] duty, logic [DUTY_W-1:0] full);
        t_mode m;
        if (duty == '0) begin
            m = MODE_OFF;
        end else if (duty == full) begin
            m = MODE_FULL;
        end else begin
            m = MODE_VAR;
        end
        return m;
    endfunction

endpackage

[design/fdhc_cand.sv]
// ----------------------------------------------------------------------------
// fdhc_cand
// Candidate duty of one sensor against its threshold set.
// ----------------------------------------------------------------------------
module fdhc_cand (
    input  logic [fdhc_pkg::TEMP_W-1:0] i_temp,
    input  logic                        i_stopped,
    input  fdhc_pkg::t_params           i_params,
    input  logic [fdhc_pkg::DUTY_W-1:0] i_duty,
    output logic [fdhc_pkg::DUTY_W-1:0] o_cand
);

    logic [fdhc_pkg::TEMP_W:0] upper;
    logic [fdhc_pkg::TEMP_W:0] temp_plus;
    logic [fdhc_pkg::DUTY_W:0] raised;
    logic                      hot;
    logic                      cold;

    assign upper     = {1'b0, i_params.setpoint} + {1'b0, i_params.temp_band};
    assign temp_plus = {1'b0, i_temp} + {1'b0, i_params.temp_band};
    assign hot       = {1'b0, i_temp} > upper;
    // t < setpoint - band, done without a sign bit
    assign cold      = temp_plus < {1'b0, i_params.setpoint};
    assign raised    = {1'b0, i_duty} + {1'b0, i_params.duty_inc};

    always_comb begin
        if (i_temp > i_params.max_temp) begin
            o_cand = i_params.max_duty;
        end else if (hot) begin
            if (i_stopped) begin
                o_cand = i_params.min_duty;
            end else if (i_duty < i_params.max_duty) begin
                o_cand = (raised > {1'b0, i_params.max_duty}) ? i_params.max_duty
                                                              : raised[fdhc_pkg::DUTY_W-1:0];
            end else begin
                o_cand = i_duty;
            end
        end else if (cold) begin
            if (i_stopped || (i_duty < i_params.duty_inc)) begin
                o_cand = '0;
            end else begin
                o_cand = i_duty - i_params.duty_inc;
            end
        end else begin
            o_cand = i_duty;
        end
    end

endmodule

[design/fdhc_outq.sv]
// ----------------------------------------------------------------------------
// fdhc_outq
// Result queue: takes up to two results a cycle, hands out one while the sink is ready.
// ----------------------------------------------------------------------------
`include "fan_duty_hysteresis_controller_macros.svh"

module fdhc_outq #(
    parameter int unsigned DEPTH = fdhc_pkg::OUTQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  fdhc_pkg::t_result i_push_a,
    input  fdhc_pkg::t_result i_push_b,
    output logic              o_room2,
    output logic              o_valid,
    input  logic              i_ready,
    output fdhc_pkg::t_result o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    fdhc_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_cnt;
    logic [AW-1:0]     n_wr_ptr;
    logic [AW-1:0]     wr_ptr_p1;
    logic [AW-1:0]     wr_ptr_p2;
    logic [AW-1:0]     rd_ptr_p1;
    logic [CW-1:0]     n_cnt;
    logic              pop;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign wr_ptr_p1 = ptr_inc(r_wr_ptr);
    assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
    assign rd_ptr_p1 = ptr_inc(r_rd_ptr);
    assign pop       = o_valid && i_ready;
    assign o_valid   = (r_cnt != '0);
    assign o_room2   = (r_cnt <= CW'(DEPTH - 2));
    assign o_head    = r_mem[r_rd_ptr];

    always_comb begin
        case (i_push_cnt)
            2'd1:    n_wr_ptr = wr_ptr_p1;
            2'd2:    n_wr_ptr = wr_ptr_p2;
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_cnt = r_cnt + CW'(i_push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_cnt    <= n_cnt;
            if (pop) begin
                r_rd_ptr <= rd_ptr_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push_b;
        end
    end

    `FDHC_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH), "queue count over depth")
    `FDHC_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push_cnt != 2'd0, o_room2, "push without room")
    `FDHC_ASSERT_NEXT(a_drain, i_clk, i_rst_n, pop && (r_cnt == CW'(1)) && (i_push_cnt == 2'd0), !o_valid, "valid held after last result taken")

endmodule

[design/fan_duty_hysteresis_controller.sv]
// ----------------------------------------------------------------------------
// fan_duty_hysteresis_controller
// Hysteresis fan speed control over a chip, a disk and an auxiliary sensor.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries three temperatures and a tach
// reading. It is held in an input register; once the result queue has room
// for two, the three candidate duties, their maximum and the compare against
// the current duty are worked out in one pass and zero, one or two results
// go into a small result queue, while the current duty register moves to the
// new value. A request that changes nothing gives no result. A request that
// spins up a stopped fan gives two: the startup kick (tlast low) and the
// final duty (tlast high). With a free-running master side one request is
// taken every cycle as long as each gives at most one result; the result
// port sends one result a cycle, so kicks can fill the queue and stall the
// slave stream. Configuration writes are taken at once (o_cfg_ready is
// always high) and are meant to happen only while no request is in flight.
// ----------------------------------------------------------------------------
module fan_duty_hysteresis_controller #(
    parameter int unsigned OUTQ_DEPTH = fdhc_pkg::OUTQ_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fdhc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fdhc_pkg::PARAM_W-1:0]   i_cfg_data,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] chip temp, [15:8] disk temp, [23:16] aux temp, [39:24] tach count
    input  logic [39:0]                    s_axis_tdata,
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] duty
    output logic [7:0]                     m_axis_tdata,
    // [1:0] fan_mode
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int unsigned DW = fdhc_pkg::DUTY_W;
    localparam int unsigned TW = fdhc_pkg::TEMP_W;

    // config registers
    fdhc_pkg::t_params                    r_soc_params;
    fdhc_pkg::t_params                    r_hdd_params;
    fdhc_pkg::t_params                    r_aux_params;
    logic [fdhc_pkg::ENABLE_W-1:0]        r_sensor_en;
    logic [DW-1:0]                        r_full_duty;
    logic [DW-1:0]                        r_startup_duty;

    // input register
    logic                                 r_in_vld;
    logic [TW-1:0]                        r_chip_t;
    logic [TW-1:0]                        r_disk_t;
    logic [TW-1:0]                        r_aux_temp;
    logic [fdhc_pkg::SPEED_W-1:0]         r_tach;

    logic [DW-1:0]                        r_cur_duty;

    logic                                 cfg_wr;
    logic                                 in_acc;
    logic                                 fire;
    logic                                 stopped;
    logic [DW-1:0]                        cand_soc;
    logic [DW-1:0]                        cand_hdd_raw;
    logic [DW-1:0]                        cand_aux_raw;
    logic [DW-1:0]                        cand_hdd;
    logic [DW-1:0]                        cand_aux;
    logic [DW-1:0]                        max_sh;
    logic [DW-1:0]                        new_duty;
    logic                                 changed;
    logic                                 kick;
    logic [1:0]                           push_cnt;
    fdhc_pkg::t_result                    res_kick;
    fdhc_pkg::t_result                    res_final;
    fdhc_pkg::t_result                    push_a;
    fdhc_pkg::t_result                    q_head;
    logic                                 q_room2;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soc_params   <= '0;
            r_hdd_params   <= '0;
            r_aux_params   <= '0;
            r_sensor_en    <= '0;
            r_full_duty    <= fdhc_pkg::FULL_SPEED_RST;
            r_startup_duty <= fdhc_pkg::STARTUP_RST;
        end else if (cfg_wr) begin
            unique case (fdhc_pkg::t_cfg_idx'(i_cfg_index))
                fdhc_pkg::CFG_SOC_PARAMS:   r_soc_params   <= fdhc_pkg::t_params'(i_cfg_data);
                fdhc_pkg::CFG_HDD_PARAMS:   r_hdd_params   <= fdhc_pkg::t_params'(i_cfg_data);
                fdhc_pkg::CFG_AUX_PARAMS:   r_aux_params   <= fdhc_pkg::t_params'(i_cfg_data);
                fdhc_pkg::CFG_SENSOR_EN:    r_sensor_en    <= i_cfg_data[fdhc_pkg::ENABLE_W-1:0];
                fdhc_pkg::CFG_FULL_SPEED:   r_full_duty    <= i_cfg_data[DW-1:0];
                fdhc_pkg::CFG_STARTUP_DUTY: r_startup_duty <= i_cfg_data[DW-1:0];
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    // The held request is consumed whenever the queue has room for two.
    assign fire          = r_in_vld && q_room2;
    assign s_axis_tready = !r_in_vld || fire;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_chip_t   <= s_axis_tdata[7:0];
            r_disk_t   <= s_axis_tdata[15:8];
            r_aux_temp <= s_axis_tdata[23:16];
            r_tach     <= s_axis_tdata[39:24];
        end
    end

    // ---------------- duty decision ----------------
    assign stopped = (r_tach == '0);

    fdhc_cand u_cand_soc (
        .i_temp    (r_chip_t),
        .i_stopped (stopped),
        .i_params  (r_soc_params),
        .i_duty    (r_cur_duty),
        .o_cand    (cand_soc)
    );

    fdhc_cand u_cand_hdd (
        .i_temp    (r_disk_t),
        .i_stopped (stopped),
        .i_params  (r_hdd_params),
        .i_duty    (r_cur_duty),
        .o_cand    (cand_hdd_raw)
    );

    fdhc_cand u_cand_aux (
        .i_temp    (r_aux_temp),
        .i_stopped (stopped),
        .i_params  (r_aux_params),
        .i_duty    (r_cur_duty),
        .o_cand    (cand_aux_raw)
    );

    // absent sensors vote zero
    assign cand_hdd = r_sensor_en[0] ? cand_hdd_raw : '0;
    assign cand_aux = r_sensor_en[1] ? cand_aux_raw : '0;
    assign max_sh   = (cand_soc > cand_hdd) ? cand_soc : cand_hdd;
    assign new_duty = (cand_aux > max_sh) ? cand_aux : max_sh;

    assign changed  = (new_duty != r_cur_duty);
    assign kick     = stopped && (new_duty > r_cur_duty);

    assign res_kick.duty  = r_startup_duty;
    assign res_kick.mode  = fdhc_pkg::mode_of(r_startup_duty, r_full_duty);
    assign res_kick.last  = 1'b0;
    assign res_final.duty = new_duty;
    assign res_final.mode = fdhc_pkg::mode_of(new_duty, r_full_duty);
    assign res_final.last = 1'b1;

    always_comb begin
        push_cnt = 2'd0;
        if (fire && changed) begin
            push_cnt = kick ? 2'd2 : 2'd1;
        end
    end

    // kick goes first when present
    assign push_a = kick ? res_kick : res_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_duty <= '0;
        end else if (fire) begin
            r_cur_duty <= new_duty;
        end
    end

    // ---------------- result queue ----------------
    fdhc_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push_a   (push_a),
        .i_push_b   (res_final),
        .o_room2    (q_room2),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_head     (q_head)
    );

    assign m_axis_tdata = q_head.duty;
    assign m_axis_tuser = q_head.mode;
    assign m_axis_tlast = q_head.last;

endmodule
